[sv/multilevel_queue_scheduler_assert.svh]
// Assertion macros for the multilevel queue scheduler.
// Included by RTL modules that carry concurrent checks; no other dependencies.
`ifndef MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MQS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MQS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mqs_pkg.sv]
// Shared constants and types for the multilevel queue scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package mqs_pkg;

  localparam int MAX_PROC   = 32;
  localparam int NUM_LEVELS = 8;
  localparam int IDX_W      = $clog2(MAX_PROC);
  localparam int CNT_W      = $clog2(MAX_PROC + 1);
  localparam int LVL_W      = $clog2(NUM_LEVELS);

  localparam int ARR_W      = 16;
  localparam int BUR_W      = 16;
  localparam int LVL_IN_W   = 3;
  localparam int ID_W       = 5;
  localparam int TIME_W     = 22;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  // Command from the loader to the scheduling engine.
  typedef struct packed {
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [ARR_W-1:0]  arr;
    logic [BUR_W-1:0]  bur;
    logic [LVL_W-1:0]  lvl;
    logic              last;
    logic [CNT_W-1:0]  n;
  } cmd_t;

endpackage

`default_nettype wire

[sv/mqs_front.sv]
// Loader front end: accepts processes, clamps levels, assigns load slots.
// Depends on mqs_pkg; feeds mqs_cmd_fifo.
`default_nettype none

module mqs_front import mqs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ARR_W-1:0]     arrival_time,
  input  wire logic [BUR_W-1:0]     burst_time,
  input  wire logic [LVL_IN_W-1:0]  queue_level,
  input  wire logic                 last_process,
  output logic                      push,
  output cmd_t                      cmd,
  input  wire logic                 q_ready
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             has_room;
  logic [CNT_W-1:0] stored;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;
  assign has_room = count < CNT_W'(MAX_PROC);
  assign stored   = has_room ? count + 1'b1 : count;

  always_comb begin
    cmd.wr   = has_room;
    cmd.idx  = count[IDX_W-1:0];
    cmd.arr  = arrival_time;
    cmd.bur  = burst_time;
    if (int'(queue_level) >= NUM_LEVELS) begin
      cmd.lvl = LVL_W'(NUM_LEVELS - 1);
    end else begin
      cmd.lvl = LVL_W'(queue_level);
    end
    cmd.last = last_process;
    cmd.n    = stored;
  end

  // Restart the count once a batch is handed over.
  assign count_next = last_process ? '0 : stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

[sv/mqs_cmd_fifo.sv]
// Short command queue between the loader and the scheduling engine.
// Depends on mqs_pkg for cmd_t and the queue depth.
`default_nettype none

module mqs_cmd_fifo import mqs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  wr_data,
  output logic       wr_ready,
  output logic       rd_valid,
  output cmd_t       rd_data,
  input  wire logic  pop
);

  cmd_t             slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  fill;
  logic             do_push;
  logic             do_pop;

  assign wr_ready = fill != Q_CW'(Q_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rd_ptr];
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/mqs_engine.sv]
// Scheduling engine: process store, selection scan, timing and result register.
// Depends on mqs_pkg and multilevel_queue_scheduler_assert.svh.
`default_nettype none
`include "multilevel_queue_scheduler_assert.svh"

module mqs_engine import mqs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ID_W-1:0]         process_id,
  output logic [ARR_W-1:0]        arrival_out,
  output logic [BUR_W-1:0]        burst_out,
  output logic [TIME_W-1:0]       completion_time,
  output logic [TIME_W-1:0]       turnaround_time,
  output logic [TIME_W-1:0]       waiting_time,
  output logic [TIME_W-1:0]       response_time,
  output logic                    last_result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  typedef struct packed {
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [LVL_W-1:0] lvl;
    logic [IDX_W-1:0] idx;
  } cand_t;

  logic [ARR_W-1:0]   mem_arr [MAX_PROC];
  logic [BUR_W-1:0]   mem_bur [MAX_PROC];
  logic [LVL_W-1:0]   mem_lvl [MAX_PROC];

  logic [2:0]         state;
  logic [MAX_PROC-1:0] done;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   picks;
  logic [IDX_W-1:0]   scan_idx;
  logic [TIME_W-1:0]  cur_time;

  logic               rd_vld;
  cand_t              rd;
  cand_t              best_a;
  cand_t              best_e;
  logic               have_a;
  logic               have_e;

  cand_t              pick;
  logic [TIME_W-1:0]  pick_start;
  logic [TIME_W-1:0]  pick_comp;

  cand_t              sel;
  logic [TIME_W-1:0]  start_c;
  logic [TIME_W:0]    sum_c;
  logic [TIME_W-1:0]  comp_c;
  logic [TIME_W-1:0]  tat_c;
  logic               arrived;
  logic               take_a;
  logic               take_e;
  logic               out_free;
  logic               last_pick;

  assign cmd_ready = state == S_IDLE;
  assign out_free  = !out_valid || out_ready;
  assign last_pick = (picks + 1'b1) == n;

  // Store writes and registered scan read.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && cmd.wr) begin
      mem_arr[cmd.idx] <= cmd.arr;
      mem_bur[cmd.idx] <= cmd.bur;
      mem_lvl[cmd.idx] <= cmd.lvl;
    end
    rd.arr <= mem_arr[scan_idx];
    rd.bur <= mem_bur[scan_idx];
    rd.lvl <= mem_lvl[scan_idx];
    rd.idx <= scan_idx;
  end

  // Candidate ranking: best_a among arrived, best_e by earliest arrival.
  assign arrived = TIME_W'(rd.arr) <= cur_time;
  assign take_a  = rd_vld && !done[rd.idx] && arrived &&
                   (!have_a || rd.lvl < best_a.lvl ||
                    (rd.lvl == best_a.lvl && rd.arr < best_a.arr));
  assign take_e  = rd_vld && !done[rd.idx] &&
                   (!have_e || rd.arr < best_e.arr ||
                    (rd.arr == best_e.arr && rd.lvl < best_e.lvl));

  // Pick and completion time.
  always_comb begin
    sel     = have_a ? best_a : best_e;
    start_c = have_a ? cur_time : TIME_W'(best_e.arr);
    sum_c   = (TIME_W+1)'(start_c) + (TIME_W+1)'(sel.bur);
    comp_c  = (sum_c > (TIME_W+1)'(TIME_MAX)) ? TIME_MAX : sum_c[TIME_W-1:0];
    tat_c   = pick_comp - TIME_W'(pick.arr);
  end

  always_ff @(posedge clk) begin
    if (take_a) begin
      best_a <= rd;
    end
    if (take_e) begin
      best_e <= rd;
    end
    if (state == S_COMP) begin
      pick       <= sel;
      pick_start <= start_c;
      pick_comp  <= comp_c;
    end
    if (state == S_EMIT && out_free) begin
      process_id      <= ID_W'(pick.idx);
      arrival_out     <= pick.arr;
      burst_out       <= pick.bur;
      completion_time <= pick_comp;
      turnaround_time <= tat_c;
      waiting_time    <= (tat_c >= TIME_W'(pick.bur)) ? tat_c - TIME_W'(pick.bur) : '0;
      response_time   <= pick_start - TIME_W'(pick.arr);
      last_result     <= last_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= '0;
      n         <= '0;
      picks     <= '0;
      scan_idx  <= '0;
      cur_time  <= '0;
      rd_vld    <= 1'b0;
      have_a    <= 1'b0;
      have_e    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_a) begin
        have_a <= 1'b1;
      end
      if (take_e) begin
        have_e <= 1'b1;
      end
      // Drop the word once taken; the emit state reloads it on its own.
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (cmd_valid && cmd.last) begin
            n        <= cmd.n;
            picks    <= '0;
            scan_idx <= '0;
            have_a   <= 1'b0;
            have_e   <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= 1'b1;
          if (CNT_W'(scan_idx) == n - 1'b1) begin
            state <= S_TAIL;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_TAIL: begin
          rd_vld <= 1'b0;
          state  <= S_COMP;
        end
        S_COMP: begin
          done[sel.idx] <= 1'b1;
          cur_time      <= comp_c;
          state         <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            picks     <= picks + 1'b1;
            scan_idx  <= '0;
            have_a    <= 1'b0;
            have_e    <= 1'b0;
            if (last_pick) begin
              done     <= '0;
              cur_time <= '0;
              state    <= S_IDLE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MQS_ASSERT_IMP(a_pick_exists, clk, rst, state == S_COMP, have_e, "no candidate at pick")
  `MQS_ASSERT_NXT(a_pick_marked, clk, rst, state == S_COMP, done[pick.idx], "pick not marked done")
  `MQS_ASSERT_IMP(a_picks_bound, clk, rst, state == S_EMIT, picks < n, "too many picks")
  `MQS_ASSERT_NXT(a_time_mono, clk, rst, state == S_COMP, cur_time >= $past(cur_time), "time went back")

endmodule

`default_nettype wire

[sv/multilevel_queue_scheduler.sv]
// Top level of the non-preemptive multilevel queue scheduler.
// Depends on mqs_pkg, mqs_front, mqs_cmd_fifo and mqs_engine.
//
//   channel  | handshake            | fields
//   ---------+----------------------+-----------------------------------------------
//   input    | in_valid / in_ready  | arrival_time burst_time queue_level last_process
//   output   | out_valid / out_ready| process_id arrival_out burst_out completion_time
//            |                      | turnaround_time waiting_time response_time
//            |                      | last_result
//
// Loading takes one word per cycle while the queue has room; the front assigns
// load slots and passes commands through a two-entry queue to the engine.
// Each result takes a scan of the process store through its single read port,
// then a tail, a pick and an emit state.
// While a batch schedules the engine takes no commands, so the queue fills and
// in_ready drops.
// Reset is synchronous; it clears slot count, done flags, time and queue state.
// The output register holds a word under out_ready low and stalls the engine.
`default_nettype none

module multilevel_queue_scheduler import mqs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ARR_W-1:0]     arrival_time,
  input  wire logic [BUR_W-1:0]     burst_time,
  input  wire logic [LVL_IN_W-1:0]  queue_level,
  input  wire logic                 last_process,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ID_W-1:0]           process_id,
  output logic [ARR_W-1:0]          arrival_out,
  output logic [BUR_W-1:0]          burst_out,
  output logic [TIME_W-1:0]         completion_time,
  output logic [TIME_W-1:0]         turnaround_time,
  output logic [TIME_W-1:0]         waiting_time,
  output logic [TIME_W-1:0]         response_time,
  output logic                      last_result
);

  // Front to queue.
  logic  push;
  cmd_t  push_cmd;
  logic  q_ready;

  // Queue to engine.
  logic  q_valid;
  cmd_t  q_cmd;
  logic  pop;

  mqs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .arrival_time (arrival_time),
    .burst_time   (burst_time),
    .queue_level  (queue_level),
    .last_process (last_process),
    .push         (push),
    .cmd          (push_cmd),
    .q_ready      (q_ready)
  );

  // Decouple loading from the scheduling scan.
  mqs_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (push_cmd),
    .wr_ready (q_ready),
    .rd_valid (q_valid),
    .rd_data  (q_cmd),
    .pop      (pop)
  );

  mqs_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (q_valid),
    .cmd             (q_cmd),
    .cmd_ready       (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .process_id      (process_id),
    .arrival_out     (arrival_out),
    .burst_out       (burst_out),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time),
    .response_time   (response_time),
    .last_result     (last_result)
  );

endmodule

`default_nettype wire

[dv/tb_multilevel_queue_scheduler.sv]
// Self-checking testbench for the non-preemptive multilevel queue scheduler.
// Depends on mqs_pkg and multilevel_queue_scheduler; it keeps its own schedule predictor
// and drives both valid/ready channels with bursts, stalls and one long output hold-off.
`default_nettype none

module tb_multilevel_queue_scheduler import mqs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // One scheduled process as the block reports it.
  typedef struct packed {
    logic [ID_W-1:0]   pid;
    logic [ARR_W-1:0]  arrival;
    logic [BUR_W-1:0]  burst;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;
    logic              last_flag;
  } sched_entry_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  localparam int SETTLE_CYCLES = 64;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ARR_W-1:0]    arrival_time = '0;
  logic [BUR_W-1:0]    burst_time = '0;
  logic [LVL_IN_W-1:0] queue_level = '0;
  logic                last_process = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ID_W-1:0]     process_id;
  logic [ARR_W-1:0]    arrival_out;
  logic [BUR_W-1:0]    burst_out;
  logic [TIME_W-1:0]   completion_time;
  logic [TIME_W-1:0]   turnaround_time;
  logic [TIME_W-1:0]   waiting_time;
  logic [TIME_W-1:0]   response_time;
  logic                last_result;

  // Predictor state: the processes of the batch being loaded.
  logic [ARR_W-1:0]    slot_arr [MAX_PROC];
  logic [BUR_W-1:0]    slot_bur [MAX_PROC];
  logic [LVL_IN_W-1:0] slot_lvl [MAX_PROC];
  int                  slot_count = 0;

  // Predicted run order, oldest first.
  sched_entry_t        schedule_q [$];
  int                  sched_errors = 0;

  // Sender and receiver idling controls.
  bit                  tx_gaps_on = 1'b0;
  int                  tx_burst_left = 1;
  rx_style_t           rx_mode = RX_ALWAYS;
  int                  rx_holdoff_req = 0;
  int                  rx_hold_left = 0;
  int                  rx_phase = 0;

  multilevel_queue_scheduler dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .queue_level     (queue_level),
    .last_process    (last_process),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .process_id      (process_id),
    .arrival_out     (arrival_out),
    .burst_out       (burst_out),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time),
    .response_time   (response_time),
    .last_result     (last_result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Schedule the loaded batch the way the block must: at each decision point jump
  // time over idle gaps, pick the lowest level among arrived processes, break ties
  // by earlier arrival and then by lower load index. Push one entry per pick.
  function automatic void run_schedule();
    bit [MAX_PROC-1:0] finished;
    longint unsigned   now, start, comp, tat, wt, resp;
    int                k, i, pick;
    int                earliest;
    bit                have, any;
    sched_entry_t      e;
    finished = '0;
    now = 0;
    for (k = 0; k < slot_count; k++) begin
      any = 1'b0;
      earliest = 0;
      for (i = 0; i < slot_count; i++) begin
        if (!finished[i] && (!any || slot_arr[i] < earliest)) begin
          earliest = slot_arr[i];
          any = 1'b1;
        end
      end
      if (!any) break;
      if (earliest > now) now = earliest;
      have = 1'b0;
      pick = 0;
      // Scan in load order, so an exact tie keeps the lower index.
      for (i = 0; i < slot_count; i++) begin
        if (finished[i] || slot_arr[i] > now) continue;
        if (!have || slot_lvl[i] < slot_lvl[pick] ||
            (slot_lvl[i] == slot_lvl[pick] && slot_arr[i] < slot_arr[pick])) begin
          pick = i;
          have = 1'b1;
        end
      end
      start = now;
      comp = start + slot_bur[pick];
      if (comp > TIME_MAX) comp = TIME_MAX;
      tat = comp - slot_arr[pick];
      wt = (tat >= slot_bur[pick]) ? tat - slot_bur[pick] : 0;
      resp = start - slot_arr[pick];
      finished[pick] = 1'b1;
      now = comp;
      e.pid        = pick[ID_W-1:0];
      e.arrival    = slot_arr[pick];
      e.burst      = slot_bur[pick];
      e.completion = comp[TIME_W-1:0];
      e.turnaround = tat[TIME_W-1:0];
      e.waiting    = wt[TIME_W-1:0];
      e.response   = resp[TIME_W-1:0];
      e.last_flag  = (k + 1 == slot_count);
      schedule_q.push_back(e);
    end
    slot_count = 0;
  endfunction

  // Offer one process word, hold it until accepted, then record it in the predictor.
  // With gaps on, drop valid at the end of each random burst.
  task automatic send_word(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                           input logic [LVL_IN_W-1:0] lvl, input logic last_flag);
    logic [LVL_IN_W-1:0] lvl_c;
    in_valid     <= 1'b1;
    arrival_time <= arr;
    burst_time   <= bur;
    queue_level  <= lvl;
    last_process <= last_flag;
    do @(posedge clk); while (!in_ready);
    lvl_c = (lvl >= NUM_LEVELS) ? LVL_IN_W'(NUM_LEVELS - 1) : lvl;
    // A full batch drops the process but still honors its last flag.
    if (slot_count < MAX_PROC) begin
      slot_arr[slot_count] = arr;
      slot_bur[slot_count] = bur;
      slot_lvl[slot_count] = lvl_c;
      slot_count++;
    end
    if (last_flag) run_schedule();
    if (tx_gaps_on) begin
      tx_burst_left--;
      if (tx_burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        tx_burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic wait_schedule_done();
    in_valid <= 1'b0;
    while (schedule_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ARR_W-1:0] rand_arrival(input int spread);
    case (spread)
      0:       return ARR_W'($urandom_range(0, 63));
      1:       return ARR_W'($urandom_range(0, 2000));
      default: return ARR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [BUR_W-1:0] rand_burst();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 2) return BUR_W'($urandom_range(0, 65535));
    return BUR_W'($urandom_range(1, 200));
  endfunction

  // Receiver: stall per the current style, or hold off completely on request.
  always @(posedge clk) begin
    if (rx_holdoff_req != 0) begin
      rx_hold_left = rx_holdoff_req;
      rx_holdoff_req = 0;
    end
    rx_phase++;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
        default:    out_ready <= ((rx_phase % 7) >= 2);
      endcase
    end
  end

  function automatic void report_word(input string why, input sched_entry_t want,
                                      input sched_entry_t got);
    sched_errors++;
    if (sched_errors <= 10) begin
      $display("%0t: %s", $realtime, why);
      $display("  want id=%0d arr=%0d bur=%0d comp=%0d tat=%0d wait=%0d resp=%0d last=%0b",
               want.pid, want.arrival, want.burst, want.completion, want.turnaround,
               want.waiting, want.response, want.last_flag);
      $display("  got  id=%0d arr=%0d bur=%0d comp=%0d tat=%0d wait=%0d resp=%0d last=%0b",
               got.pid, got.arrival, got.burst, got.completion, got.turnaround,
               got.waiting, got.response, got.last_flag);
    end
  endfunction

  // Checker: compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    sched_entry_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{process_id, arrival_out, burst_out, completion_time, turnaround_time,
              waiting_time, response_time, last_result};
      if (schedule_q.size() == 0) begin
        report_word("result word with nothing predicted", '0, got);
      end else begin
        want = schedule_q.pop_front();
        if (got.pid !== want.pid || got.arrival !== want.arrival ||
            got.burst !== want.burst || got.completion !== want.completion ||
            got.turnaround !== want.turnaround || got.waiting !== want.waiting ||
            got.response !== want.response || got.last_flag !== want.last_flag)
          report_word("result word mismatch", want, got);
      end
    end
  end

  // A batch of one, with every input field at its top value.
  task automatic test_lone_process();
    tx_gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    send_word(16'hFFFF, 16'hFFFF, 3'd7, 1'b1);
    wait_schedule_done();
  endtask

  // Zero burst, exact ties broken by load index, and ties on level broken by arrival.
  task automatic test_ties_and_zero_burst();
    rx_mode = RX_PATTERN;
    send_word(16'd0, 16'd0, 3'd0, 1'b0);
    send_word(16'd0, 16'd5, 3'd3, 1'b0);
    send_word(16'd0, 16'd5, 3'd3, 1'b0);
    send_word(16'd2, 16'd4, 3'd3, 1'b0);
    send_word(16'd1, 16'd7, 3'd3, 1'b0);
    send_word(16'd4, 16'd2, 3'd1, 1'b1);
    wait_schedule_done();
  endtask

  // Arrivals far apart, so time must jump over idle stretches.
  task automatic test_idle_gap();
    rx_mode = RX_RANDOM;
    send_word(16'd1000, 16'd10, 3'd5, 1'b0);
    send_word(16'd10, 16'd20, 3'd2, 1'b0);
    send_word(16'd40000, 16'd1, 3'd0, 1'b0);
    send_word(16'hFFFF, 16'd0, 3'd4, 1'b1);
    wait_schedule_done();
  endtask

  // Every level at once, all arriving together; run with no idling on either side.
  task automatic test_level_order();
    int i;
    tx_gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    for (i = 0; i < NUM_LEVELS; i++)
      send_word(16'd0, BUR_W'(3 * (i + 1)), LVL_IN_W'(NUM_LEVELS - 1 - i),
                i == NUM_LEVELS - 1);
    wait_schedule_done();
  endtask

  // Random batches, mostly small, with arrivals dense, medium or spread over the full range.
  task automatic test_random_batches(input int target);
    int sent, n, i, spread;
    sent = 0;
    tx_gaps_on = 1'b1;
    while (sent < target) begin
      rx_mode = ($urandom_range(0, 1) != 0) ? RX_RANDOM : RX_PATTERN;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, MAX_PROC) : $urandom_range(1, 8);
      spread = $urandom_range(0, 2);
      for (i = 0; i < n; i++)
        send_word(rand_arrival(spread), rand_burst(), LVL_IN_W'($urandom_range(0, 7)),
                  i == n - 1);
      sent += n;
    end
    wait_schedule_done();
  endtask

  // Overfill a batch; the dropped tail carries the last flag.
  task automatic test_batch_overflow();
    int i;
    tx_gaps_on = 1'b1;
    rx_mode = RX_PATTERN;
    for (i = 0; i < MAX_PROC + 3; i++)
      send_word(rand_arrival(1), rand_burst(), LVL_IN_W'($urandom_range(0, 7)),
                i == MAX_PROC + 2);
    wait_schedule_done();
  endtask

  // Hold the receiver off for a long stretch while full-rate batches keep coming,
  // so the command queue fills and input stalls.
  task automatic test_output_holdoff();
    int i;
    tx_gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    rx_holdoff_req = 800;
    for (i = 0; i < MAX_PROC; i++)
      send_word(rand_arrival(0), rand_burst(), LVL_IN_W'($urandom_range(0, 7)),
                i == MAX_PROC - 1);
    for (i = 0; i < 12; i++)
      send_word(rand_arrival(2), rand_burst(), LVL_IN_W'($urandom_range(0, 7)), i == 11);
    for (i = 0; i < 6; i++)
      send_word(rand_arrival(1), rand_burst(), LVL_IN_W'($urandom_range(0, 7)), i == 5);
    wait_schedule_done();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lone_process();
    test_ties_and_zero_burst();
    test_idle_gap();
    test_level_order();
    test_random_batches(60);
    test_batch_overflow();
    test_output_holdoff();
    if (sched_errors == 0 && schedule_q.size() == 0)
      $display("multilevel_queue_scheduler test passed");
    else
      $display("multilevel_queue_scheduler test failed");
    $finish;
  end

  // Bound the run well past the slowest legal schedule.
  initial begin
    #10ms;
    $display("multilevel_queue_scheduler test failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/mqs_pkg.sv
sv/mqs_front.sv
sv/mqs_cmd_fifo.sv
sv/mqs_engine.sv
sv/multilevel_queue_scheduler.sv
dv/tb_multilevel_queue_scheduler.sv
